@@ sv/irrctl_pkg.sv @@
// shared codes, field widths and register reset values for the irrigation event controller
package irrctl_pkg;

    localparam int EV_W    = 3;
    localparam int MODE_W  = 3;
    localparam int TEMP_W  = 11;
    localparam int HUM_W   = 10;
    localparam int SOIL_W  = 12;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 12;
    localparam int S_DATA_W  = 40;
    localparam int M_DATA_W  = 8;

    // event codes
    localparam logic [EV_W-1:0] EV_SENSOR   = 3'd0;
    localparam logic [EV_W-1:0] EV_SCHED    = 3'd1;
    localparam logic [EV_W-1:0] EV_BUTTON   = 3'd2;
    localparam logic [EV_W-1:0] EV_PUMPDONE = 3'd3;
    localparam logic [EV_W-1:0] EV_WAITDONE = 3'd4;
    localparam logic [EV_W-1:0] EV_WEATHER  = 3'd5;
    localparam logic [EV_W-1:0] EV_ERROR    = 3'd6;
    localparam logic [EV_W-1:0] EV_UNUSED   = 3'd7;

    // mode codes
    localparam logic [MODE_W-1:0] MODE_IDLE  = 3'd0;
    localparam logic [MODE_W-1:0] MODE_WATER = 3'd1;
    localparam logic [MODE_W-1:0] MODE_WAIT  = 3'd2;
    localparam logic [MODE_W-1:0] MODE_ALERT = 3'd3;
    localparam logic [MODE_W-1:0] MODE_ERROR = 3'd4;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SOIL_DRY  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SOIL_WET  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HUM_ALARM = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_HEAT_ALARM   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_HEAT_RECOVER = 3'd4;

    // register reset values
    localparam logic [SOIL_W-1:0]        RST_SOIL_DRY     = 12'd2800;
    localparam logic [SOIL_W-1:0]        RST_SOIL_WET     = 12'd1500;
    localparam logic [HUM_W-1:0]         RST_HUM_ALARM    = 10'd300;
    localparam logic signed [TEMP_W-1:0] RST_HEAT_ALARM   = 11'sd380;
    localparam logic signed [TEMP_W-1:0] RST_HEAT_RECOVER = 11'sd350;

    typedef struct packed {
        logic [EV_W-1:0]          ev;
        logic signed [TEMP_W-1:0] temp;
        logic [HUM_W-1:0]         hum;
        logic [SOIL_W-1:0]        soil;
        logic                     rain;
    } t_event;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic              pump;
        logic              alarm;
        logic              start_wait;
    } t_result;

endpackage

@@ sv/irrigation_event_controller.sv @@
// irrigation event controller: mode state machine driven by sensor and control events
//
// channel   dir  handshake                     payload
// s_axis    in   s_axis_tvalid/s_axis_tready   tuser: req_type; tdata: readings, rain flag
// m_axis    out  m_axis_tvalid/m_axis_tready   tdata: mode, pump, alarm, start_wait
// cfg       in   i_cfg_wr_en (no wait)         i_cfg_index, i_cfg_wdata
//
// one event per cycle sustained while m_axis is not stalled; each event passes through the
// input register, then the result register, before its result can transfer
// the mode and reading registers update in the same cycle the result is registered,
// so the next event sees them with no bubble
// a stall on m_axis holds the result register; the input register then fills and
// s_axis_tready drops until the result is taken
// reset (synchronous, active low) returns idle mode, clears readings, pump, alarm and
// rain flag, and loads the threshold defaults
module irrigation_event_controller (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // [10:0] temperature, [20:11] humidity, [32:21] soil_reading, [33] rain_now, rest zero
    input  logic [irrctl_pkg::S_DATA_W-1:0]     s_axis_tdata,
    // [2:0] req_type
    input  logic [irrctl_pkg::EV_W-1:0]         s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // [2:0] mode, [3] pump_on, [4] alarm_on, [5] start_wait, [7:6] zero
    output logic [irrctl_pkg::M_DATA_W-1:0]     m_axis_tdata,
    input  logic                                i_cfg_wr_en,
    input  logic [irrctl_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [irrctl_pkg::CFG_DAT_W-1:0]    i_cfg_wdata
);
    import irrctl_pkg::*;

    // threshold registers
    logic [SOIL_W-1:0]        r_soil_dry;
    logic [SOIL_W-1:0]        r_soil_wet;
    logic [HUM_W-1:0]         r_hum_alarm;
    logic signed [TEMP_W-1:0] r_heat_alarm;
    logic signed [TEMP_W-1:0] r_heat_recover;

    // controller state
    logic [MODE_W-1:0]        r_mode,  n_mode;
    logic signed [TEMP_W-1:0] r_temp,  n_temp;
    logic [HUM_W-1:0]         r_hum,   n_hum;
    logic [SOIL_W-1:0]        r_soil,  n_soil;
    logic                     r_rain,  n_rain;
    logic                     r_pump,  n_pump;
    logic                     r_alarm, n_alarm;
    logic                     n_pulse;

    // input register and result register
    logic    r_in_valid;
    t_event  r_in;
    logic    r_out_valid;
    t_result r_out;

    logic advance;
    logic alarm_cond;

    assign advance       = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {2'b00, r_out.start_wait, r_out.alarm, r_out.pump, r_out.mode};

    // configuration writes, taken at once with no wait
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_soil_dry     <= RST_SOIL_DRY;
            r_soil_wet     <= RST_SOIL_WET;
            r_hum_alarm    <= RST_HUM_ALARM;
            r_heat_alarm   <= RST_HEAT_ALARM;
            r_heat_recover <= RST_HEAT_RECOVER;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_SOIL_DRY:     r_soil_dry     <= i_cfg_wdata;
                CFG_SOIL_WET:     r_soil_wet     <= i_cfg_wdata;
                CFG_HUM_ALARM:    r_hum_alarm    <= i_cfg_wdata[HUM_W-1:0];
                CFG_HEAT_ALARM:   r_heat_alarm   <= i_cfg_wdata[TEMP_W-1:0];
                CFG_HEAT_RECOVER: r_heat_recover <= i_cfg_wdata[TEMP_W-1:0];
                default: ;
            endcase
        end
    end

    // input register: holds one event until the result register has room
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in.ev   <= s_axis_tuser;
            r_in.temp <= s_axis_tdata[10:0];
            r_in.hum  <= s_axis_tdata[20:11];
            r_in.soil <= s_axis_tdata[32:21];
            r_in.rain <= s_axis_tdata[33];
        end
    end

    // alarm test runs on the readings after a sensor update
    assign alarm_cond = (n_hum < r_hum_alarm) && (n_temp > r_heat_alarm);

    // next state for the event in the input register
    always_comb begin
        n_mode  = r_mode;
        n_temp  = r_temp;
        n_hum   = r_hum;
        n_soil  = r_soil;
        n_rain  = r_rain;
        n_pump  = r_pump;
        n_alarm = r_alarm;
        n_pulse = 1'b0;

        if (r_in.ev == EV_SENSOR) begin
            n_temp = r_in.temp;
            n_hum  = r_in.hum;
            n_soil = r_in.soil;
        end

        if (r_in.ev == EV_ERROR) begin
            n_mode  = MODE_ERROR;
            n_pump  = 1'b0;
            n_alarm = 1'b1;
        end else if (r_in.ev == EV_WEATHER) begin
            n_rain = r_in.rain;
        end else if (r_in.ev == EV_BUTTON) begin
            // toggle watering; from any other mode the alarm level is kept
            if (r_mode != MODE_WATER) begin
                n_mode = MODE_WATER;
                n_pump = 1'b1;
            end else begin
                n_mode  = MODE_WAIT;
                n_pump  = 1'b0;
                n_pulse = 1'b1;
            end
        end else if (r_in.ev == EV_UNUSED) begin
            // unused code: state reported as it stands
        end else if (!(r_in.ev == EV_SCHED && r_rain)) begin
            case (r_mode)
                MODE_IDLE: begin
                    if (r_in.ev == EV_SCHED && n_soil > r_soil_wet) begin
                        n_mode = MODE_WATER;
                        n_pump = 1'b1;
                    end else if (r_in.ev == EV_SENSOR) begin
                        if (alarm_cond) begin
                            n_mode  = MODE_ALERT;
                            n_pump  = 1'b0;
                            n_alarm = 1'b1;
                        end else if (n_soil > r_soil_dry) begin
                            n_mode = MODE_WATER;
                            n_pump = 1'b1;
                        end
                    end
                end
                MODE_WATER: begin
                    if ((r_in.ev == EV_SENSOR && n_soil < r_soil_wet) ||
                        r_in.ev == EV_PUMPDONE) begin
                        n_mode  = MODE_WAIT;
                        n_pump  = 1'b0;
                        n_pulse = 1'b1;
                    end
                end
                MODE_WAIT: begin
                    if (r_in.ev == EV_WAITDONE) begin
                        n_mode = MODE_IDLE;
                    end
                end
                MODE_ALERT: begin
                    if (r_in.ev == EV_SENSOR &&
                        (n_temp <= r_heat_recover || n_hum >= r_hum_alarm)) begin
                        n_mode  = MODE_IDLE;
                        n_alarm = 1'b0;
                    end
                end
                MODE_ERROR: begin
                    if (r_in.ev == EV_SENSOR) begin
                        if (alarm_cond) begin
                            n_mode  = MODE_ALERT;
                            n_pump  = 1'b0;
                            n_alarm = 1'b1;
                        end else begin
                            n_mode  = MODE_IDLE;
                            n_alarm = 1'b0;
                        end
                    end
                end
                default: begin
                    n_mode = MODE_IDLE;
                end
            endcase
        end
    end

    // state and result move together on each advance
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= MODE_IDLE;
            r_temp      <= '0;
            r_hum       <= '0;
            r_soil      <= '0;
            r_rain      <= 1'b0;
            r_pump      <= 1'b0;
            r_alarm     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (advance) begin
                r_mode  <= n_mode;
                r_temp  <= n_temp;
                r_hum   <= n_hum;
                r_soil  <= n_soil;
                r_rain  <= n_rain;
                r_pump  <= n_pump;
                r_alarm <= n_alarm;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out.mode       <= n_mode;
            r_out.pump       <= n_pump;
            r_out.alarm      <= n_alarm;
            r_out.start_wait <= n_pulse;
        end
    end

    // a wait-timer start pulse only comes with waiting mode and the pump off
    a_pulse_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.start_wait |-> r_out.mode == MODE_WAIT && !r_out.pump)
        else $error("start_wait outside waiting mode");

    // error and alert modes drive the alarm and keep the pump off
    a_fault_outputs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && (r_out.mode == MODE_ERROR || r_out.mode == MODE_ALERT)
        |-> r_out.alarm && !r_out.pump)
        else $error("alarm or pump wrong in error or alert mode");

    // watering mode always has the pump running
    a_water_pump: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.mode == MODE_WATER |-> r_out.pump)
        else $error("pump off in watering mode");

    // the result register mirrors the live state
    a_result_matches_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> r_out.mode == r_mode && r_out.pump == r_pump
                        && r_out.alarm == r_alarm)
        else $error("result register out of step with state");

endmodule

@@ tb/irrigation_result_checker.sv @@
// checker for the irrigation event controller: predicts each result and compares transfers
module irrigation_result_checker (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             s_axis_tvalid,
    input  logic                             s_axis_tready,
    input  logic [irrctl_pkg::S_DATA_W-1:0]  s_axis_tdata,
    input  logic [irrctl_pkg::EV_W-1:0]      s_axis_tuser,
    input  logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    input  logic [irrctl_pkg::M_DATA_W-1:0]  m_axis_tdata,
    input  logic                             i_cfg_wr_en,
    input  logic [irrctl_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [irrctl_pkg::CFG_DAT_W-1:0] i_cfg_wdata,
    output int                               o_fail_count,
    output int                               o_pending
);
    import irrctl_pkg::*;

    // threshold copies
    logic [SOIL_W-1:0]        dry_level;
    logic [SOIL_W-1:0]        wet_level;
    logic [HUM_W-1:0]         hum_level;
    logic signed [TEMP_W-1:0] heat_level;
    logic signed [TEMP_W-1:0] recover_level;

    // controller state copies
    logic [MODE_W-1:0]        mode_now;
    logic signed [TEMP_W-1:0] temp_seen;
    logic [HUM_W-1:0]         hum_seen;
    logic [SOIL_W-1:0]        soil_seen;
    logic                     rain_flag;
    logic                     pump_level;
    logic                     alarm_level;

    t_result expected_results[$];

    function automatic logic alarm_wanted();
        return (hum_seen < hum_level) && (temp_seen > heat_level);
    endfunction

    function automatic t_result next_controller_result(input t_event e);
        t_result r;
        logic    pulse;
        pulse = 1'b0;
        case (e.ev)
            EV_ERROR: begin
                mode_now    = MODE_ERROR;
                pump_level  = 1'b0;
                alarm_level = 1'b1;
            end
            EV_WEATHER: begin
                rain_flag = e.rain;
            end
            EV_BUTTON: begin
                if (mode_now != MODE_WATER) begin
                    mode_now   = MODE_WATER;
                    pump_level = 1'b1;
                end else begin
                    mode_now   = MODE_WAIT;
                    pump_level = 1'b0;
                    pulse      = 1'b1;
                end
            end
            EV_UNUSED: begin
            end
            default: begin
                if (!(e.ev == EV_SCHED && rain_flag)) begin
                    if (e.ev == EV_SENSOR) begin
                        temp_seen = e.temp;
                        hum_seen  = e.hum;
                        soil_seen = e.soil;
                    end
                    case (mode_now)
                        MODE_IDLE: begin
                            if (e.ev == EV_SCHED && soil_seen > wet_level) begin
                                mode_now   = MODE_WATER;
                                pump_level = 1'b1;
                            end else if (e.ev == EV_SENSOR) begin
                                if (alarm_wanted()) begin
                                    mode_now    = MODE_ALERT;
                                    pump_level  = 1'b0;
                                    alarm_level = 1'b1;
                                end else if (soil_seen > dry_level) begin
                                    mode_now   = MODE_WATER;
                                    pump_level = 1'b1;
                                end
                            end
                        end
                        MODE_WATER: begin
                            if ((e.ev == EV_SENSOR && soil_seen < wet_level) ||
                                e.ev == EV_PUMPDONE) begin
                                mode_now   = MODE_WAIT;
                                pump_level = 1'b0;
                                pulse      = 1'b1;
                            end
                        end
                        MODE_WAIT: begin
                            if (e.ev == EV_WAITDONE) mode_now = MODE_IDLE;
                        end
                        MODE_ALERT: begin
                            if (e.ev == EV_SENSOR && (temp_seen <= recover_level ||
                                                      hum_seen >= hum_level)) begin
                                alarm_level = 1'b0;
                                mode_now    = MODE_IDLE;
                            end
                        end
                        MODE_ERROR: begin
                            if (e.ev == EV_SENSOR) begin
                                if (alarm_wanted()) begin
                                    mode_now    = MODE_ALERT;
                                    pump_level  = 1'b0;
                                    alarm_level = 1'b1;
                                end else begin
                                    mode_now    = MODE_IDLE;
                                    alarm_level = 1'b0;
                                end
                            end
                        end
                        default: begin
                            mode_now = MODE_IDLE;
                        end
                    endcase
                end
            end
        endcase
        r.mode       = mode_now;
        r.pump       = pump_level;
        r.alarm      = alarm_level;
        r.start_wait = pulse;
        return r;
    endfunction

    task automatic compare_field(input string field_name, input logic [MODE_W-1:0] want,
                                 input logic [MODE_W-1:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, actual %0d", field_name, want, got);
            o_fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_event  e;
        t_result want;
        if (!i_rst_n) begin
            dry_level     = RST_SOIL_DRY;
            wet_level     = RST_SOIL_WET;
            hum_level     = RST_HUM_ALARM;
            heat_level    = RST_HEAT_ALARM;
            recover_level = RST_HEAT_RECOVER;
            mode_now      = MODE_IDLE;
            temp_seen     = '0;
            hum_seen      = '0;
            soil_seen     = '0;
            rain_flag     = 1'b0;
            pump_level    = 1'b0;
            alarm_level   = 1'b0;
            expected_results.delete();
            o_fail_count  = 0;
            o_pending     = 0;
        end else begin
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    CFG_SOIL_DRY:     dry_level     = i_cfg_wdata;
                    CFG_SOIL_WET:     wet_level     = i_cfg_wdata;
                    CFG_HUM_ALARM:    hum_level     = i_cfg_wdata[HUM_W-1:0];
                    CFG_HEAT_ALARM:   heat_level    = i_cfg_wdata[TEMP_W-1:0];
                    CFG_HEAT_RECOVER: recover_level = i_cfg_wdata[TEMP_W-1:0];
                    default: begin
                    end
                endcase
            end
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_results.size() == 0) begin
                    $error("result transfer with no expectation waiting: tdata %h",
                           m_axis_tdata);
                    o_fail_count++;
                end else begin
                    want = expected_results.pop_front();
                    compare_field("mode", want.mode, m_axis_tdata[2:0]);
                    compare_field("pump_on", MODE_W'(want.pump), MODE_W'(m_axis_tdata[3]));
                    compare_field("alarm_on", MODE_W'(want.alarm), MODE_W'(m_axis_tdata[4]));
                    compare_field("start_wait", MODE_W'(want.start_wait),
                                  MODE_W'(m_axis_tdata[5]));
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                e.ev   = s_axis_tuser;
                e.temp = s_axis_tdata[10:0];
                e.hum  = s_axis_tdata[20:11];
                e.soil = s_axis_tdata[32:21];
                e.rain = s_axis_tdata[33];
                expected_results.push_back(next_controller_result(e));
            end
            o_pending = expected_results.size();
        end
    end

endmodule

@@ tb/irrigation_event_controller_test.sv @@
// top of the irrigation event controller testbench: clock, reset, stimulus and verdict
module irrigation_event_controller_test;
    import irrctl_pkg::*;

    localparam int CYCLE_LIMIT     = 200000;
    localparam int ITEMS_PER_PHASE = 200;
    localparam int PHASE_COUNT     = 7;
    localparam int HOLD_CYCLES     = 150;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    // [10:0] temperature, [20:11] humidity, [32:21] soil_reading, [33] rain_now, rest zero
    logic [S_DATA_W-1:0]  s_axis_tdata;
    // [2:0] req_type
    logic [EV_W-1:0]      s_axis_tuser;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    // [2:0] mode, [3] pump_on, [4] alarm_on, [5] start_wait, [7:6] zero
    logic [M_DATA_W-1:0]  m_axis_tdata;
    logic                 i_cfg_wr_en;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [CFG_DAT_W-1:0] i_cfg_wdata;

    int fail_count;
    int pending;
    int cycle_count = 0;

    // idle chances in percent for the sender and the receiver
    int tx_idle_pct = 26;
    int rx_idle_pct = 26;

    // a long receiver hold-off is asked by bumping the request count
    int rx_hold_requests = 0;
    int rx_hold_served   = 0;
    int rx_hold_left     = 0;

    // thresholds currently loaded, used to aim readings near the switch points
    logic [SOIL_W-1:0]        thr_dry;
    logic [SOIL_W-1:0]        thr_wet;
    logic [HUM_W-1:0]         thr_hum;
    logic signed [TEMP_W-1:0] thr_heat;
    logic signed [TEMP_W-1:0] thr_rec;

    irrigation_event_controller i_dut (.*);

    irrigation_result_checker i_checker (
        .*,
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // give up if the run hangs
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("Mismatches found");
        $finish;
    end

    // result side: random back-pressure plus an occasional long hold-off
    initial begin
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (rx_hold_requests != rx_hold_served) begin
                rx_hold_served++;
                rx_hold_left = HOLD_CYCLES;
            end
            if (rx_hold_left > 0) begin
                rx_hold_left--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
            end
        end
    end

    function automatic t_event ev_item(input logic [EV_W-1:0] ev,
                                       input logic signed [TEMP_W-1:0] temp,
                                       input logic [HUM_W-1:0] hum,
                                       input logic [SOIL_W-1:0] soil, input logic rain);
        t_event e;
        e.ev   = ev;
        e.temp = temp;
        e.hum  = hum;
        e.soil = soil;
        e.rain = rain;
        return e;
    endfunction

    // random event, readings near the loaded thresholds, in the usual range or anywhere in the field
    function automatic t_event random_event();
        t_event e;
        int     pick;
        int     t;
        pick = $urandom_range(0, 99);
        if (pick < 40)      e.ev = EV_SENSOR;
        else if (pick < 50) e.ev = EV_SCHED;
        else if (pick < 58) e.ev = EV_BUTTON;
        else if (pick < 68) e.ev = EV_PUMPDONE;
        else if (pick < 80) e.ev = EV_WAITDONE;
        else if (pick < 88) e.ev = EV_WEATHER;
        else if (pick < 96) e.ev = EV_ERROR;
        else                e.ev = EV_UNUSED;
        case ($urandom_range(0, 3))
            0:       t = int'(thr_heat) + int'($urandom_range(0, 8)) - 4;
            1:       t = int'(thr_rec) + int'($urandom_range(0, 8)) - 4;
            2:       t = int'($urandom_range(0, 1250)) - 400;
            default: t = int'($urandom_range(0, 2047)) - 1024;
        endcase
        e.temp = t[TEMP_W-1:0];
        case ($urandom_range(0, 2))
            0:       t = int'(thr_hum) + int'($urandom_range(0, 8)) - 4;
            1:       t = int'($urandom_range(0, 1000));
            default: t = int'($urandom_range(0, 1023));
        endcase
        e.hum = t[HUM_W-1:0];
        case ($urandom_range(0, 2))
            0:       t = int'(thr_dry) + int'($urandom_range(0, 8)) - 4;
            1:       t = int'(thr_wet) + int'($urandom_range(0, 8)) - 4;
            default: t = int'($urandom_range(0, 4095));
        endcase
        e.soil = t[SOIL_W-1:0];
        e.rain = 1'($urandom_range(0, 1));
        return e;
    endfunction

    // offer one event, with random idle cycles first; returns at the falling edge
    // after the transfer, valid still high
    task automatic send_event(input t_event e);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(S_DATA_W-34){1'b0}}, e.rain, e.soil, e.hum, e.temp};
        s_axis_tuser  <= e.ev;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DAT_W-1:0] value);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= value;
        @(negedge i_clk);
    endtask

    // loads all five thresholds; unused upper write bits get random junk
    task automatic load_thresholds(input logic [SOIL_W-1:0] dry, input logic [SOIL_W-1:0] wet,
                                   input logic [HUM_W-1:0] hum,
                                   input logic signed [TEMP_W-1:0] heat,
                                   input logic signed [TEMP_W-1:0] rec);
        thr_dry  = dry;
        thr_wet  = wet;
        thr_hum  = hum;
        thr_heat = heat;
        thr_rec  = rec;
        write_register(CFG_SOIL_DRY, dry);
        write_register(CFG_SOIL_WET, wet);
        write_register(CFG_HUM_ALARM, {2'($urandom_range(0, 3)), hum});
        write_register(CFG_HEAT_ALARM, {1'($urandom_range(0, 1)), heat});
        write_register(CFG_HEAT_RECOVER, {1'($urandom_range(0, 1)), rec});
        i_cfg_wr_en <= 1'b0;
    endtask

    // sender pause: every expected result in, then a settling wait before the next phase
    task automatic wait_for_results();
        while (pending != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    initial begin
        int phase;
        int k;
        int heat_i;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = EV_SENSOR;
        i_cfg_wr_en   = 1'b0;
        i_cfg_index   = CFG_SOIL_DRY;
        i_cfg_wdata   = '0;
        thr_dry       = RST_SOIL_DRY;
        thr_wet       = RST_SOIL_WET;
        thr_hum       = RST_HUM_ALARM;
        thr_heat      = RST_HEAT_ALARM;
        thr_rec       = RST_HEAT_RECOVER;
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed walk through the modes with the reset thresholds
        // unused code changes nothing
        send_event(ev_item(EV_UNUSED, 11'sd1023, 10'd1023, 12'd4095, 1'b1));
        // dry soil starts watering, wet soil stops it with the wait pulse
        send_event(ev_item(EV_SENSOR, 11'sd0, 10'd500, 12'd4095, 1'b0));
        send_event(ev_item(EV_SENSOR, 11'sd0, 10'd500, 12'd0, 1'b1));
        send_event(ev_item(EV_WAITDONE, 11'sd0, 10'd0, 12'd0, 1'b0));
        // hot and dry air raises the alert; still above recover keeps it
        send_event(ev_item(EV_SENSOR, 11'sd850, 10'd0, 12'd0, 1'b0));
        send_event(ev_item(EV_SENSOR, 11'sd360, 10'd0, 12'd0, 1'b0));
        // button from alert waters with the alarm left on
        send_event(ev_item(EV_BUTTON, 11'sd0, 10'd0, 12'd0, 1'b0));
        send_event(ev_item(EV_PUMPDONE, 11'sd0, 10'd0, 12'd0, 1'b0));
        send_event(ev_item(EV_WAITDONE, 11'sd0, 10'd0, 12'd0, 1'b1));
        // scheduled trigger ignored while raining
        send_event(ev_item(EV_WEATHER, 11'sd0, 10'd0, 12'd0, 1'b1));
        send_event(ev_item(EV_SCHED, 11'sd0, 10'd0, 12'd0, 1'b0));
        send_event(ev_item(EV_SENSOR, 11'sd0, 10'd500, 12'd2000, 1'b0));
        send_event(ev_item(EV_SCHED, 11'sd0, 10'd0, 12'd0, 1'b0));
        send_event(ev_item(EV_WEATHER, 11'sd0, 10'd0, 12'd0, 1'b0));
        send_event(ev_item(EV_SCHED, 11'sd0, 10'd0, 12'd0, 1'b1));
        // button while watering goes to waiting
        send_event(ev_item(EV_BUTTON, 11'sd0, 10'd0, 12'd0, 1'b0));
        // error from any mode, button out of error
        send_event(ev_item(EV_ERROR, 11'sd0, 10'd0, 12'd0, 1'b0));
        send_event(ev_item(EV_BUTTON, 11'sd0, 10'd0, 12'd0, 1'b0));
        send_event(ev_item(EV_ERROR, 11'sd0, 10'd0, 12'd0, 1'b1));
        send_event(ev_item(EV_SENSOR, -11'sd400, 10'd1000, 12'd0, 1'b0));
        send_event(ev_item(EV_ERROR, 11'sd0, 10'd0, 12'd0, 1'b0));
        // out-of-range temperatures compared as they are
        send_event(ev_item(EV_SENSOR, 11'sd1023, 10'd0, 12'd0, 1'b0));
        send_event(ev_item(EV_SENSOR, 11'h400, 10'd0, 12'd0, 1'b1));
        send_event(ev_item(EV_PUMPDONE, 11'sd0, 10'd0, 12'd0, 1'b0));
        s_axis_tvalid <= 1'b0;

        for (phase = 0; phase < PHASE_COUNT; phase++) begin
            wait_for_results();
            case (phase)
                0: load_thresholds(RST_SOIL_DRY, RST_SOIL_WET, RST_HUM_ALARM,
                                   RST_HEAT_ALARM, RST_HEAT_RECOVER);
                1: load_thresholds(12'd0, 12'd0, 10'd0, -11'sd400, -11'sd400);
                2: load_thresholds(12'd4095, 12'd4095, 10'd1000, 11'sd850, 11'sd850);
                // full field width extremes
                3: load_thresholds(12'd4095, 12'd0, 10'd1023, 11'h400, 11'sd1023);
                default: begin
                    heat_i = int'($urandom_range(0, 1250)) - 400;
                    load_thresholds(12'($urandom_range(1500, 4095)),
                                    12'($urandom_range(0, 2000)),
                                    10'($urandom_range(0, 1000)), 11'(heat_i),
                                    11'(heat_i - int'($urandom_range(0, 100))));
                end
            endcase
            // one phase runs back to back with no idling on either side
            tx_idle_pct = (phase == 4) ? 0 : 26;
            rx_idle_pct = (phase == 4) ? 0 : 26;
            // long result-side hold-off while events keep coming, so the input stalls
            if (phase == 5) rx_hold_requests++;
            for (k = 0; k < ITEMS_PER_PHASE; k++) send_event(random_event());
            s_axis_tvalid <= 1'b0;
        end

        wait_for_results();
        repeat (6) @(negedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
